// ----- sv/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define SBH_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sbh assertion failed");

// implication checked on every clock edge outside reset
`define SBH_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbh implication failed");

`endif

// ----- sv/sbh_pkg.sv -----
// types and constants for the string name hash bucket
package sbh_pkg;

    localparam int HASH_W  = 29;
    localparam int T_W     = 31;
    localparam int BYTE_W  = 8;
    localparam int BUCKET_W = 10;
    localparam int MUL_W   = 19;
    localparam int PROD_W  = MUL_W + BYTE_W;
    localparam int CFG_W   = 11;
    localparam int APB_W   = 32;
    localparam int ADDR_W  = 3;
    localparam int DIV_STEPS = HASH_W;
    localparam int CNT_W   = $clog2(DIV_STEPS);

    localparam logic [MUL_W-1:0]  HASH_MUL = 19'd314159;
    localparam logic [HASH_W-1:0] HASH_P   = 29'd516595003;

    localparam logic [CFG_W-1:0]  NUM_BUCKETS_RST = 11'd1;
    localparam logic              REG_NUM_BUCKETS = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_RED1,
        ST_RED2,
        ST_DIV,
        ST_EMIT
    } state_t;

endpackage

// ----- sv/sbh_if.sv -----
// request and result channel interfaces
interface sbh_req_if;
    import sbh_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] name_byte;
    logic              last;

    modport source (output valid, output name_byte, output last, input ready);
    modport sink (input valid, input name_byte, input last, output ready);
endinterface

interface sbh_rsp_if;
    import sbh_pkg::*;

    logic                valid;
    logic                ready;
    logic [BUCKET_W-1:0] bucket;
    logic [HASH_W-1:0]   hash_value;

    modport source (output valid, output bucket, output hash_value, input ready);
    modport sink (input valid, input bucket, input hash_value, output ready);
endinterface

// ----- sv/string_name_hash_bucket.sv -----
// top level of the string name hash bucket
// a byte without the last flag goes through accept, add, two reductions
// a last byte goes through accept, 3 hash steps, 29 remainder steps, 1 output load
// a full output register holds the block in emit until the waiting result is taken
// async active-low reset clears the running hash and sets num_buckets to 1
`include "assert_macros.svh"

module string_name_hash_bucket #(
    parameter int MAX_BUCKETS = 1024
) (
    input  logic                     clk,
    input  logic                     rst_n,
    sbh_req_if.sink                  req,
    sbh_rsp_if.source                rsp,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [sbh_pkg::ADDR_W-1:0] paddr,
    input  logic [sbh_pkg::APB_W-1:0]  pwdata,
    output logic [sbh_pkg::APB_W-1:0]  prdata,
    output logic                     pready
);
    import sbh_pkg::*;

    localparam int NW = $clog2(MAX_BUCKETS + 1);

    state_t             state_reg, state_next;
    logic [BYTE_W-1:0]  byte_reg;
    logic               last_reg;
    logic [HASH_W-1:0]  hash_reg, hash_next;
    logic [T_W-1:0]     t_reg, t_next;
    logic [HASH_W-1:0]  res_reg, res_next;
    logic [HASH_W-1:0]  div_reg, div_next;
    logic [NW-1:0]      rem_reg, rem_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CFG_W-1:0]   num_buckets_reg;
    logic               out_valid_reg, out_valid_next;
    logic [BUCKET_W-1:0] out_bucket_reg;
    logic [HASH_W-1:0]  out_hash_reg;

    logic               req_acc;
    logic               out_load;
    logic               cfg_wr;
    logic [31:0]        cfg_wide;
    logic [NW-1:0]      n_eff;
    logic [PROD_W-1:0]  prod;
    logic [T_W-1:0]     unit_a, unit_b, unit_y;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_NUM_BUCKETS);
    assign prdata = (paddr[ADDR_W-1] == REG_NUM_BUCKETS) ? APB_W'(num_buckets_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_buckets_reg <= NUM_BUCKETS_RST;
        end
        else if (cfg_wr)
        begin
            num_buckets_reg <= pwdata[CFG_W-1:0];
        end
    end

    // zero means one bucket, large counts saturate
    always_comb
    begin
        cfg_wide = 32'(num_buckets_reg);
        if (cfg_wide == 32'd0)
        begin
            cfg_wide = 32'd1;
        end
        if (cfg_wide > 32'(MAX_BUCKETS))
        begin
            cfg_wide = 32'(MAX_BUCKETS);
        end
        n_eff = cfg_wide[NW-1:0];
    end

    // shared unit
    always_comb
    begin
        case (state_reg)
            ST_DIV:
            begin
                unit_a = T_W'({rem_reg, div_reg[HASH_W-1]});
                unit_b = T_W'(n_eff);
            end
            default:
            begin
                unit_a = t_reg;
                unit_b = T_W'(HASH_P);
            end
        endcase
    end

    sbh_csub #(
        .W (T_W)
    ) u_csub (
        .a  (unit_a),
        .b  (unit_b),
        .y  (unit_y)
    );

    assign prod     = PROD_W'(HASH_MUL) * PROD_W'(byte_reg);
    assign req_acc  = req.valid && req.ready;
    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || rsp.ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (req_acc) state_next = ST_ADD;
            ST_ADD:  state_next = ST_RED1;
            ST_RED1: state_next = ST_RED2;
            ST_RED2: state_next = last_reg ? ST_DIV : ST_IDLE;
            ST_DIV:  if (cnt_reg == CNT_W'(DIV_STEPS - 1)) state_next = ST_EMIT;
            ST_EMIT: if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        req.ready = (state_reg == ST_IDLE);
    end

    // datapath
    always_comb
    begin
        hash_next = hash_reg;
        t_next    = t_reg;
        res_next  = res_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        case (state_reg)
            ST_ADD:
            begin
                t_next = T_W'(hash_reg) + T_W'(hash_reg ^ (hash_reg >> 1)) + T_W'(prod);
            end
            ST_RED1:
            begin
                t_next = unit_y;
            end
            ST_RED2:
            begin
                res_next  = unit_y[HASH_W-1:0];
                div_next  = unit_y[HASH_W-1:0];
                rem_next  = '0;
                cnt_next  = '0;
                hash_next = last_reg ? '0 : unit_y[HASH_W-1:0];
            end
            ST_DIV:
            begin
                rem_next = unit_y[NW-1:0];
                div_next = {div_reg[HASH_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hash_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            byte_reg <= req.name_byte;
            last_reg <= req.last;
        end
        t_reg   <= t_next;
        res_reg <= res_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
        if (out_load)
        begin
            out_bucket_reg <= BUCKET_W'(rem_reg);
            out_hash_reg   <= res_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.bucket     = out_bucket_reg;
    assign rsp.hash_value = out_hash_reg;

    `SBH_ASSERT(a_hash_below_prime, hash_reg < HASH_P)
    `SBH_ASSERT_IMP(a_clear_after_last, (state_reg == ST_RED2) && last_reg, ##1 (hash_reg == '0))
    `SBH_ASSERT_IMP(a_result_from_emit, $rose(rsp.valid), $past(state_reg == ST_EMIT))
    `SBH_ASSERT_IMP(a_bucket_in_range, rsp.valid, NW'(rsp.bucket) < n_eff)

endmodule

// ----- sv/sbh_csub.sv -----
// shared compare and conditional subtract unit
module sbh_csub #(
    parameter int W = 31
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] y
);

    logic ge;

    always_comb
    begin
        ge = (a >= b);
        y  = ge ? (a - b) : a;
    end

endmodule
